/* rtl/polygon_wall_bounce_step_core_defines.svh */
// Assertion macros for the polygon wall bounce step core.
// Depends on nothing; included by the files that carry assertions.
`ifndef POLYGON_WALL_BOUNCE_STEP_CORE_DEFINES_SVH
`define POLYGON_WALL_BOUNCE_STEP_CORE_DEFINES_SVH

// same-cycle implication
`define PWB_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PWB_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pwb_pkg.sv */
// Shared widths, codes and control structs of the polygon wall bounce step core.
// Depends on nothing.
package pwb_pkg;

  localparam int POS_W        = 21;
  localparam int VEL_W        = 17;
  localparam int DT_W         = 16;
  localparam int IDX_W        = 3;
  localparam int VC_W         = 4;
  localparam int KIND_W       = 2;
  localparam int MAX_VERTICES = 8;
  localparam int SQRT_STEPS   = 30;
  localparam int DIV_STEPS    = 16;

  localparam logic       OP_LOAD     = 1'b0;
  localparam logic       OP_STEP     = 1'b1;
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_CORNER = 2'd1;
  localparam logic [1:0] KIND_EDGE   = 2'd2;

  // request to the root / divide unit
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [59:0] s;
    logic [44:0] num;
    logic [29:0] den;
  } pwb_rd_ctl_t;

  typedef struct packed {
    logic        busy;
    logic [29:0] res;
  } pwb_rd_sts_t;

endpackage

/* rtl/pwb_ifs.sv */
// Valid/ready channel interfaces for step items and results.
// Depends on pwb_pkg.
interface pwb_in_if;
  import pwb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [IDX_W-1:0]        vertex_index;
  logic signed [POS_W-1:0] vertex_x;
  logic signed [POS_W-1:0] vertex_y;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic [DT_W-1:0]         time_step;
  modport source (output valid, op, vertex_index, vertex_x, vertex_y, pos_x, pos_y,
                  vel_x, vel_y, time_step, input ready);
  modport sink (input valid, op, vertex_index, vertex_x, vertex_y, pos_x, pos_y,
                vel_x, vel_y, time_step, output ready);
endinterface

interface pwb_out_if;
  import pwb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] new_pos_x;
  logic signed [POS_W-1:0] new_pos_y;
  logic signed [VEL_W-1:0] new_vel_x;
  logic signed [VEL_W-1:0] new_vel_y;
  logic [KIND_W-1:0]       bounce_kind;
  logic [IDX_W-1:0]        bounce_vertex;
  modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                  bounce_kind, bounce_vertex, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                bounce_kind, bounce_vertex, output ready);
endinterface

/* rtl/pwb_rootdiv.sv */
// Iterative square root / unsigned divide unit, one bit per cycle on a shared
// 34-bit subtractor. Depends on pwb_pkg.
module pwb_rootdiv (
  input  logic                  clk,
  input  logic                  rst,
  input  pwb_pkg::pwb_rd_ctl_t  ctl,
  output pwb_pkg::pwb_rd_sts_t  sts
);
  import pwb_pkg::*;

  logic        busy;
  logic        is_div;
  logic [4:0]  cnt;
  logic [59:0] sh;
  logic [33:0] rem;
  logic [29:0] res;
  logic [29:0] den;
  logic [33:0] cand;
  logic [33:0] sub;
  logic [33:0] diff;
  logic        ge;

  always_comb begin
    cand = is_div ? {rem[32:0], sh[59]} : {rem[31:0], sh[59:58]};
    sub  = is_div ? {4'b0, den} : {2'b0, res, 2'b01};
    ge   = cand >= sub;
    diff = cand - sub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 5'd0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      is_div <= ctl.is_div;
      den    <= ctl.den;
      res    <= '0;
      if (ctl.is_div) begin
        rem <= {5'b0, ctl.num[44:16]};
        sh  <= {ctl.num[15:0], 44'b0};
        cnt <= 5'(DIV_STEPS - 1);
      end else begin
        rem <= '0;
        sh  <= ctl.s;
        cnt <= 5'(SQRT_STEPS - 1);
      end
    end else if (busy) begin
      rem <= ge ? diff : cand;
      res <= {res[28:0], ge};
      sh  <= is_div ? {sh[58:0], 1'b0} : {sh[57:0], 2'b0};
      cnt <= cnt - 5'd1;
    end
  end

  assign sts.busy = busy;
  assign sts.res  = res;

endmodule

/* rtl/polygon_wall_bounce_step_core.sv */
// Polygon wall bounce step core: vertex table plus one-point bounce/advance step.
// Step duration depends on the vertex count and the bounce kind, and is set by the shared 36x23
// multiplier and the bit-serial root/divide unit (up to three unit vectors on a corner
// bounce).
// One item in flight; the next is taken once the result sits in the output register.
// Reset (rst, synchronous, active high): idle, no result pending, vertex_count = 3.
`include "polygon_wall_bounce_step_core_defines.svh"

module polygon_wall_bounce_step_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [pwb_pkg::VC_W-1:0]   cfg_wr_data,
  pwb_in_if.sink                     items,
  pwb_out_if.source                  results
);
  import pwb_pkg::*;

  localparam int NS = 35;

  typedef enum logic [NS-1:0] {
    S_IDLE    = NS'(1) << 0,
    S_C_RD    = NS'(1) << 1,
    S_C_SQX   = NS'(1) << 2,
    S_C_SQY   = NS'(1) << 3,
    S_C_CMP   = NS'(1) << 4,
    S_K_RN    = NS'(1) << 5,
    S_K_RN2   = NS'(1) << 6,
    S_K_RP    = NS'(1) << 7,
    S_U_SQA   = NS'(1) << 8,
    S_U_SQB   = NS'(1) << 9,
    S_U_ROOT  = NS'(1) << 10,
    S_U_WROOT = NS'(1) << 11,
    S_U_DIVA  = NS'(1) << 12,
    S_U_DIVB  = NS'(1) << 13,
    S_U_RET   = NS'(1) << 14,
    S_R_DXA   = NS'(1) << 15,
    S_R_DXB   = NS'(1) << 16,
    S_R_DOT   = NS'(1) << 17,
    S_R_VX    = NS'(1) << 18,
    S_R_VY    = NS'(1) << 19,
    S_E_MX    = NS'(1) << 20,
    S_E_MY    = NS'(1) << 21,
    S_E_RD    = NS'(1) << 22,
    S_E_RD1   = NS'(1) << 23,
    S_E_RD2   = NS'(1) << 24,
    S_E_M1    = NS'(1) << 25,
    S_E_M2    = NS'(1) << 26,
    S_E_M3    = NS'(1) << 27,
    S_E_M4    = NS'(1) << 28,
    S_E_M5    = NS'(1) << 29,
    S_E_M6    = NS'(1) << 30,
    S_E_M7    = NS'(1) << 31,
    S_A_X     = NS'(1) << 32,
    S_A_Y     = NS'(1) << 33,
    S_FIN     = NS'(1) << 34
  } state_t;

  // which unit vector the shared normalise sequence is producing
  typedef enum logic [1:0] {
    PH_A = 2'd0,   // outgoing edge of the corner
    PH_B = 2'd1,   // incoming edge of the corner
    PH_N = 2'd2,   // corner normal
    PH_E = 2'd3    // edge normal
  } phase_t;

  state_t state;
  phase_t uph;

  // configuration
  logic [VC_W-1:0] vc;

  // vertex table, one registered read port
  logic signed [POS_W-1:0] tab_x [MAX_VERTICES];
  logic signed [POS_W-1:0] tab_y [MAX_VERTICES];
  logic [IDX_W-1:0]        ra;
  logic signed [POS_W-1:0] rdx, rdy;

  // step working registers
  logic signed [POS_W-1:0] px, py, cx, cy, ux, uy;
  logic signed [VEL_W-1:0] vx, vy;
  logic [DT_W-1:0]         dt;
  logic [IDX_W-1:0]        i, n_last, nxt, prv;
  logic [KIND_W-1:0]       kind;
  logic [IDX_W-1:0]        which;
  logic signed [59:0]      acc;
  logic signed [22:0]      ea, eb;
  logic [29:0]             l;
  logic signed [VEL_W-1:0] uqx, uqy, ax, ay, nx, ny;
  logic signed [35:0]      dotr;
  logic signed [17:0]      mx, my;
  logic signed [21:0]      qx, qy, wx, wy;
  logic signed [41:0]      den;
  logic                    ok1;

  // shared multiplier
  logic signed [35:0] mul_a;
  logic signed [22:0] mul_b;
  logic signed [58:0] prod;
  logic signed [58:0] pr_r, pr_d;
  logic signed [29:0] rr;
  logic signed [17:0] d18;
  logic signed [21:0] ex_c, ey_c;
  logic [21:0]        abs_a, abs_b;
  logic signed [VEL_W-1:0] q_pos;

  // output register
  logic                    ovalid;
  logic signed [POS_W-1:0] o_px, o_py;
  logic signed [VEL_W-1:0] o_vx, o_vy;
  logic [KIND_W-1:0]       o_kind;
  logic [IDX_W-1:0]        o_which;

  pwb_rd_ctl_t rd_ctl;
  pwb_rd_sts_t rd_sts;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [31:0] v);
    if (v > 32'sd65535) begin
      return 17'sd65535;
    end else if (v < -32'sd65536) begin
      return -17'sd65536;
    end
    return 17'(v);
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [22:0] v);
    if (v > 23'sd1048575) begin
      return 21'sd1048575;
    end else if (v < -23'sd1048576) begin
      return -21'sd1048576;
    end
    return 21'(v);
  endfunction

  // parameter in [0,1]: num between 0 and den inclusive, either sign of den
  function automatic logic in_unit(input logic signed [59:0] num,
                                   input logic signed [41:0] d);
    logic signed [59:0] dw;
    dw = 60'(d);
    if (dw > 60'sd0) begin
      return (num >= 60'sd0) && (num <= dw);
    end
    return (num <= 60'sd0) && (num >= dw);
  endfunction

  assign items.ready = (state == S_IDLE);

  assign nxt = (i == n_last) ? '0 : i + 3'd1;
  assign prv = (i == '0) ? n_last : i - 3'd1;

  assign ex_c  = 22'(px) - 22'(rdx);
  assign ey_c  = 22'(py) - 22'(cy);
  assign abs_a = ea[22] ? 22'(-ea) : 22'(ea);
  assign abs_b = eb[22] ? 22'(-eb) : 22'(eb);
  assign q_pos = 17'({1'b0, rd_sts.res[15:0]});

  // operand selection for the multiplier and the table read address
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    ra    = i;
    case (state)
      S_C_SQX: begin mul_a = 36'(ex_c); mul_b = 23'(ex_c); end
      S_C_SQY: begin mul_a = 36'(ey_c); mul_b = 23'(ey_c); end
      S_K_RN:  ra = nxt;
      S_K_RN2: ra = prv;
      S_E_RD1: ra = nxt;
      S_U_SQA: begin mul_a = 36'(ea); mul_b = ea; end
      S_U_SQB: begin mul_a = 36'(eb); mul_b = eb; end
      S_R_DXA: begin mul_a = 36'(vx); mul_b = 23'(nx); end
      S_R_DXB: begin mul_a = 36'(vy); mul_b = 23'(ny); end
      S_R_VX:  begin mul_a = dotr; mul_b = 23'(nx); end
      S_R_VY:  begin mul_a = dotr; mul_b = 23'(ny); end
      S_E_MX, S_A_X: begin mul_a = 36'(vx); mul_b = 23'($signed({1'b0, dt})); end
      S_E_MY, S_A_Y: begin mul_a = 36'(vy); mul_b = 23'($signed({1'b0, dt})); end
      S_E_M1:  begin mul_a = 36'(qy); mul_b = 23'(mx); end
      S_E_M2:  begin mul_a = 36'(qx); mul_b = 23'(my); end
      S_E_M3:  begin mul_a = 36'(qy); mul_b = 23'(wx); end
      S_E_M4:  begin mul_a = 36'(qx); mul_b = 23'(wy); end
      S_E_M5:  begin mul_a = 36'(wx); mul_b = 23'(my); end
      S_E_M6:  begin mul_a = 36'(wy); mul_b = 23'(mx); end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;
  // reflection term: round(2*dot*n / 2^30) == round(dot*n / 2^29), half up
  assign pr_r = prod + 59'sd268435456;
  assign rr   = $signed(pr_r[58:29]);
  // displacement: round(v*dt / 2^16), half up
  assign pr_d = prod + 59'sd32768;
  assign d18  = $signed(pr_d[33:16]);

  // root / divide unit requests
  always_comb begin
    rd_ctl.start  = (state == S_U_ROOT) ||
                    (state == S_U_WROOT && !rd_sts.busy && rd_sts.res != '0) ||
                    (state == S_U_DIVA && !rd_sts.busy);
    rd_ctl.is_div = (state != S_U_ROOT);
    rd_ctl.s      = {acc[43:0], 16'b0};
    rd_ctl.num    = (state == S_U_DIVA) ? {abs_b, 23'b0} : {abs_a, 23'b0};
    rd_ctl.den    = (state == S_U_WROOT) ? rd_sts.res : l;
  end

  pwb_rootdiv u_rootdiv (
    .clk (clk),
    .rst (rst),
    .ctl (rd_ctl),
    .sts (rd_sts)
  );

  // vertex table
  always_ff @(posedge clk) begin
    if (items.valid && items.ready && items.op == OP_LOAD) begin
      tab_x[items.vertex_index] <= items.vertex_x;
      tab_y[items.vertex_index] <= items.vertex_y;
    end
    rdx <= tab_x[ra];
    rdy <= tab_y[ra];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= VC_W'(3);
    end else if (cfg_wr_en) begin
      vc <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      if (state == S_FIN && (!ovalid || results.ready)) begin
        ovalid <= 1'b1;
      end else if (ovalid && results.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (items.valid && items.op == OP_STEP) begin
            state <= S_C_RD;
          end
        end
        S_C_RD:    state <= S_C_SQX;
        S_C_SQX:   state <= S_C_SQY;
        S_C_SQY:   state <= S_C_CMP;
        S_C_CMP: begin
          if (acc < 60'sd262144) begin
            state <= S_K_RN;
          end else if (i == n_last) begin
            state <= S_E_MX;
          end else begin
            state <= S_C_RD;
          end
        end
        S_K_RN:    state <= S_K_RN2;
        S_K_RN2:   state <= S_K_RP;
        S_K_RP:    state <= S_U_SQA;
        S_U_SQA:   state <= S_U_SQB;
        S_U_SQB:   state <= S_U_ROOT;
        S_U_ROOT:  state <= S_U_WROOT;
        S_U_WROOT: begin
          if (!rd_sts.busy) begin
            state <= (rd_sts.res == '0) ? S_U_RET : S_U_DIVA;
          end
        end
        S_U_DIVA:  if (!rd_sts.busy) state <= S_U_DIVB;
        S_U_DIVB:  if (!rd_sts.busy) state <= S_U_RET;
        S_U_RET: begin
          if (uph == PH_A || uph == PH_B) begin
            state <= S_U_SQA;
          end else begin
            state <= S_R_DXA;
          end
        end
        S_R_DXA:   state <= S_R_DXB;
        S_R_DXB:   state <= S_R_DOT;
        S_R_DOT:   state <= S_R_VX;
        S_R_VX:    state <= S_R_VY;
        S_R_VY:    state <= S_A_X;
        S_E_MX:    state <= S_E_MY;
        S_E_MY:    state <= S_E_RD;
        S_E_RD:    state <= S_E_RD1;
        S_E_RD1:   state <= S_E_RD2;
        S_E_RD2:   state <= S_E_M1;
        S_E_M1:    state <= S_E_M2;
        S_E_M2:    state <= S_E_M3;
        S_E_M3:    state <= S_E_M4;
        S_E_M4:    state <= S_E_M5;
        S_E_M5:    state <= S_E_M6;
        S_E_M6:    state <= S_E_M7;
        S_E_M7: begin
          if (den != '0 && ok1 && in_unit(acc, den)) begin
            state <= S_U_SQA;
          end else if (i == n_last) begin
            state <= S_A_X;
          end else begin
            state <= S_E_RD;
          end
        end
        S_A_X:     state <= S_A_Y;
        S_A_Y:     state <= S_FIN;
        S_FIN: begin
          if (!ovalid || results.ready) begin
            state <= S_IDLE;
          end
        end
        default:   state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        px    <= items.pos_x;
        py    <= items.pos_y;
        vx    <= items.vel_x;
        vy    <= items.vel_y;
        dt    <= items.time_step;
        i     <= '0;
        kind  <= KIND_NONE;
        which <= '0;
        if (vc < VC_W'(3)) begin
          n_last <= IDX_W'(2);
        end else if (vc > VC_W'(MAX_VERTICES)) begin
          n_last <= IDX_W'(MAX_VERTICES - 1);
        end else begin
          n_last <= IDX_W'(vc - VC_W'(1));
        end
      end
      S_C_SQX: begin
        cx  <= rdx;
        cy  <= rdy;
        acc <= 60'(prod);
      end
      S_C_SQY: acc <= acc + 60'(prod);
      S_C_CMP: begin
        if (acc < 60'sd262144) begin
          kind  <= KIND_CORNER;
          which <= i;
        end else if (i != n_last) begin
          i <= i + 3'd1;
        end
      end
      S_K_RN2: begin
        ea <= 23'(rdx) - 23'(cx);
        eb <= 23'(rdy) - 23'(cy);
      end
      S_K_RP: begin
        ux  <= rdx;
        uy  <= rdy;
        uph <= PH_A;
      end
      S_U_SQA: acc <= 60'(prod);
      S_U_SQB: acc <= acc + 60'(prod);
      S_U_WROOT: begin
        if (!rd_sts.busy) begin
          l <= rd_sts.res;
          if (rd_sts.res == '0) begin
            uqx <= '0;
            uqy <= '0;
          end
        end
      end
      S_U_DIVA: if (!rd_sts.busy) uqx <= ea[22] ? -q_pos : q_pos;
      S_U_DIVB: if (!rd_sts.busy) uqy <= eb[22] ? -q_pos : q_pos;
      S_U_RET: begin
        case (uph)
          PH_A: begin
            ax  <= uqx;
            ay  <= uqy;
            ea  <= 23'(cx) - 23'(ux);
            eb  <= 23'(cy) - 23'(uy);
            uph <= PH_B;
          end
          PH_B: begin
            // normal is perpendicular to the summed unit edges
            ea  <= -(23'(ay) + 23'(uqy));
            eb  <= 23'(ax) + 23'(uqx);
            uph <= PH_N;
          end
          default: begin
            nx <= uqx;
            ny <= uqy;
          end
        endcase
      end
      S_R_DXA: acc <= 60'(prod);
      S_R_DXB: acc <= acc + 60'(prod);
      S_R_DOT: dotr <= acc[35:0];
      S_R_VX:  vx <= sat_vel(32'(vx) - 32'(rr));
      S_R_VY:  vy <= sat_vel(32'(vy) - 32'(rr));
      S_E_MX:  mx <= d18;
      S_E_MY: begin
        my <= d18;
        i  <= '0;
      end
      S_E_RD1: begin
        cx <= rdx;
        cy <= rdy;
      end
      S_E_RD2: begin
        qx <= 22'(rdx) - 22'(cx);
        qy <= 22'(rdy) - 22'(cy);
        wx <= 22'(cx) - 22'(px);
        wy <= 22'(cy) - 22'(py);
      end
      S_E_M1: acc <= 60'(prod);
      S_E_M2: acc <= acc - 60'(prod);
      S_E_M3: begin
        den <= acc[41:0];
        acc <= 60'(prod);
      end
      S_E_M4: acc <= acc - 60'(prod);
      S_E_M5: begin
        ok1 <= in_unit(acc, den);
        acc <= 60'(prod);
      end
      S_E_M6: acc <= acc - 60'(prod);
      S_E_M7: begin
        if (den != '0 && ok1 && in_unit(acc, den)) begin
          kind  <= KIND_EDGE;
          which <= i;
          ea    <= -23'(qy);
          eb    <= 23'(qx);
          uph   <= PH_E;
        end else if (i != n_last) begin
          i <= i + 3'd1;
        end
      end
      S_A_X: px <= sat_pos(23'(px) + 23'(d18));
      S_A_Y: py <= sat_pos(23'(py) + 23'(d18));
      S_FIN: begin
        if (!ovalid || results.ready) begin
          o_px    <= px;
          o_py    <= py;
          o_vx    <= vx;
          o_vy    <= vy;
          o_kind  <= kind;
          o_which <= which;
        end
      end
      default: ;
    endcase
  end

  assign results.valid         = ovalid;
  assign results.new_pos_x     = o_px;
  assign results.new_pos_y     = o_py;
  assign results.new_vel_x     = o_vx;
  assign results.new_vel_y     = o_vy;
  assign results.bounce_kind   = o_kind;
  assign results.bounce_vertex = o_which;

  `PWB_ASSERT_NOW(a_kind_legal, clk, rst, results.valid, results.bounce_kind == KIND_NONE || results.bounce_kind == KIND_CORNER || results.bounce_kind == KIND_EDGE, "bounce kind out of range")
  `PWB_ASSERT_NOW(a_none_zero, clk, rst, results.valid && results.bounce_kind == KIND_NONE, results.bounce_vertex == '0, "no bounce but vertex set")
  `PWB_ASSERT_NEXT(a_step_busy, clk, rst, items.valid && items.ready && items.op == OP_STEP, !items.ready, "ready right after a step transaction")
  `PWB_ASSERT_NOW(a_rd_start, clk, rst, rd_ctl.start, !rd_sts.busy, "root/divide restarted while busy")

endmodule
